// ===== rtl/tlvp_pkg.sv =====
package tlvp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_IPV4_TYPE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IPV6_TYPE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOMAIN_TYPE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_THRESH = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FACTS_TYPE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FACTS_LEN   = 3'd5;

  localparam logic [ByteW-1:0] IPV4_TYPE_RST   = 8'd1;
  localparam logic [ByteW-1:0] IPV6_TYPE_RST   = 8'd2;
  localparam logic [ByteW-1:0] DOMAIN_TYPE_RST = 8'd3;
  localparam logic [ByteW-1:0] SKIP_THRESH_RST = 8'd128;
  localparam logic [ByteW-1:0] FACTS_TYPE_RST  = 8'd128;
  localparam logic [ByteW-1:0] FACTS_LEN_RST   = 8'd8;

  localparam logic [ByteW-1:0] IPV4_LEN = 8'd4;
  localparam logic [ByteW-1:0] IPV6_LEN = 8'd16;
  localparam logic [ByteW-1:0] TALLY_MAX = 8'd255;

  typedef struct packed {
    logic [ByteW-1:0] ipv4_type;
    logic [ByteW-1:0] ipv6_type;
    logic [ByteW-1:0] domain_type;
    logic [ByteW-1:0] skip_thresh;
    logic [ByteW-1:0] facts_type;
    logic [ByteW-1:0] facts_len;
  } cfg_t;

  typedef struct packed {
    logic             header_valid;
    logic [ByteW-1:0] entry_type;
    logic [ByteW-1:0] entry_length;
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic             payload_end;
    logic             buffer_done;
    logic             verdict;
    logic [ByteW-1:0] known_count;
  } result_t;

  typedef enum logic [3:0] {
    PH_TYPE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_e;

endpackage

// ===== rtl/tlvp_cfg.sv =====
module tlvp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tlvp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tlvp_pkg::ByteW-1:0]      cfg_data_i,
  output tlvp_pkg::cfg_t                  cfg_o
);

  tlvp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ipv4_type   <= tlvp_pkg::IPV4_TYPE_RST;
      cfg_q.ipv6_type   <= tlvp_pkg::IPV6_TYPE_RST;
      cfg_q.domain_type <= tlvp_pkg::DOMAIN_TYPE_RST;
      cfg_q.skip_thresh <= tlvp_pkg::SKIP_THRESH_RST;
      cfg_q.facts_type  <= tlvp_pkg::FACTS_TYPE_RST;
      cfg_q.facts_len   <= tlvp_pkg::FACTS_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tlvp_pkg::CFG_IPV4_TYPE:   cfg_q.ipv4_type   <= cfg_data_i;
        tlvp_pkg::CFG_IPV6_TYPE:   cfg_q.ipv6_type   <= cfg_data_i;
        tlvp_pkg::CFG_DOMAIN_TYPE: cfg_q.domain_type <= cfg_data_i;
        tlvp_pkg::CFG_SKIP_THRESH: cfg_q.skip_thresh <= cfg_data_i;
        tlvp_pkg::CFG_FACTS_TYPE:  cfg_q.facts_type  <= cfg_data_i;
        tlvp_pkg::CFG_FACTS_LEN:   cfg_q.facts_len   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tlvp_parse.sv =====
module tlvp_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tlvp_pkg::cfg_t             cfg_i,
  input  logic                       accept_i,
  input  logic [tlvp_pkg::ByteW-1:0] data_byte_i,
  input  logic                       last_byte_i,
  output tlvp_pkg::result_t          result_o
);

  tlvp_pkg::phase_e           phase_q, phase_d, phase_mid;
  logic [tlvp_pkg::ByteW-1:0] held_type_q, held_type_d;
  logic [tlvp_pkg::ByteW-1:0] left_q, left_d, left_mid, left_dec;
  logic [tlvp_pkg::ByteW-1:0] tally_q, tally_d, tally_mid;
  logic                       known_q, known_d, known_mid;
  logic                       err_q, err_d, err_mid;
  logic                       bump;
  tlvp_pkg::result_t          res;

  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_mid   = phase_q;
    held_type_d = held_type_q;
    left_mid    = left_q;
    known_mid   = known_q;
    err_mid     = err_q;
    bump        = 1'b0;
    res         = '0;

    case (phase_q)
      tlvp_pkg::PH_TYPE: begin
        held_type_d = data_byte_i;
        if (data_byte_i == cfg_i.ipv4_type || data_byte_i == cfg_i.ipv6_type) begin
          known_mid        = 1'b1;
          left_mid         = (data_byte_i == cfg_i.ipv4_type) ? tlvp_pkg::IPV4_LEN
                                                               : tlvp_pkg::IPV6_LEN;
          res.header_valid = 1'b1;
          res.entry_type   = data_byte_i;
          res.entry_length = left_mid;
          phase_mid        = tlvp_pkg::PH_PAY;
        end else if (data_byte_i == cfg_i.domain_type ||
                     data_byte_i >= cfg_i.skip_thresh) begin
          phase_mid = tlvp_pkg::PH_LEN;
        end else begin
          err_mid   = 1'b1;
          phase_mid = tlvp_pkg::PH_DROP;
        end
      end
      tlvp_pkg::PH_LEN: begin
        if (held_type_q != cfg_i.domain_type && held_type_q == cfg_i.facts_type &&
            data_byte_i != cfg_i.facts_len) begin
          // sender facts with the wrong length: stop parsing this buffer
          err_mid   = 1'b1;
          phase_mid = tlvp_pkg::PH_DROP;
        end else begin
          known_mid = (held_type_q == cfg_i.domain_type) ||
                      (held_type_q == cfg_i.facts_type);
          if (known_mid) begin
            res.header_valid = 1'b1;
            res.entry_type   = held_type_q;
            res.entry_length = data_byte_i;
          end
          left_mid = data_byte_i;
          if (data_byte_i == '0) begin
            bump      = known_mid;
            phase_mid = tlvp_pkg::PH_TYPE;
          end else begin
            phase_mid = tlvp_pkg::PH_PAY;
          end
        end
      end
      tlvp_pkg::PH_PAY: begin
        left_mid = left_dec;
        if (known_q) begin
          res.payload_valid = 1'b1;
          res.payload_byte  = data_byte_i;
          res.entry_type    = held_type_q;
        end
        if (left_dec == '0) begin
          phase_mid       = tlvp_pkg::PH_TYPE;
          res.payload_end = known_q;
          bump            = known_q;
        end
      end
      default: ;
    endcase

    tally_mid = (bump && tally_q != tlvp_pkg::TALLY_MAX) ? tally_q + 8'd1 : tally_q;
    res.known_count = tally_mid;

    phase_d = phase_mid;
    left_d  = left_mid;
    known_d = known_mid;
    err_d   = err_mid;
    tally_d = tally_mid;
    if (last_byte_i) begin
      res.buffer_done = 1'b1;
      res.verdict     = err_mid || (phase_mid != tlvp_pkg::PH_TYPE);
      // rearm for the next buffer
      phase_d = tlvp_pkg::PH_TYPE;
      left_d  = '0;
      known_d = 1'b0;
      err_d   = 1'b0;
      tally_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tlvp_pkg::PH_TYPE;
      held_type_q <= '0;
      left_q      <= '0;
      known_q     <= 1'b0;
      err_q       <= 1'b0;
      tally_q     <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      held_type_q <= held_type_d;
      left_q      <= left_d;
      known_q     <= known_d;
      err_q       <= err_d;
      tally_q     <= tally_d;
    end
  end

  assign result_o = res;

endmodule

// ===== rtl/tlvp_out_buf.sv =====
module tlvp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tlvp_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output tlvp_pkg::result_t data_o
);

  logic              main_v_q, skid_v_q;
  tlvp_pkg::result_t main_q, skid_q;
  logic              pop;

  assign pop = main_v_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

  assign full_o  = skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

endmodule

// ===== rtl/tlv_extension_parser.sv =====
// Streaming parser for a buffer of type-length-value extension entries.
// Input channel: one buffer byte per item on data_byte_i, with last_byte_i
// set on the final byte; in_valid_i/in_stall_o form the handshake.
// Output channel: one result item per input byte (header, payload and
// end-of-buffer verdict fields); out_valid_o/out_stall_i form the handshake.
// Configuration: write cfg_data_i to register cfg_index_i while cfg_we_i is
// high; write only while the block is idle.
// Output register: an accepted byte's result is registered in the output buffer.
// Throughput: one byte per cycle while in_stall_o is low; the parse state
// updates once per accepted byte; results land in a two-deep output buffer.
// Stall: when out_stall_i holds, the buffer absorbs one more result and then
// raises in_stall_o until the receiver takes a result.
// Reset: parse state returns to "expect type byte", the entry count and error
// flag clear, configuration returns to its defaults, both buffers empty.
// The consumer discards a buffer's output when its verdict is 1.
module tlv_extension_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tlvp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tlvp_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tlvp_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         header_valid_o,
  output logic [tlvp_pkg::ByteW-1:0]   entry_type_o,
  output logic [tlvp_pkg::ByteW-1:0]   entry_length_o,
  output logic                         payload_valid_o,
  output logic [tlvp_pkg::ByteW-1:0]   payload_byte_o,
  output logic                         payload_end_o,
  output logic                         buffer_done_o,
  output logic                         verdict_o,
  output logic [tlvp_pkg::ByteW-1:0]   known_count_o
);

  tlvp_pkg::cfg_t    cfg;
  tlvp_pkg::result_t res, res_out;
  logic              accept;
  logic              full;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  tlvp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tlvp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .result_o    (res)
  );

  tlvp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign header_valid_o  = res_out.header_valid;
  assign entry_type_o    = res_out.entry_type;
  assign entry_length_o  = res_out.entry_length;
  assign payload_valid_o = res_out.payload_valid;
  assign payload_byte_o  = res_out.payload_byte;
  assign payload_end_o   = res_out.payload_end;
  assign buffer_done_o   = res_out.buffer_done;
  assign verdict_o       = res_out.verdict;
  assign known_count_o   = res_out.known_count;

`ifndef SYNTHESIS
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output buffer is empty");

  a_header_not_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(header_valid_o && payload_valid_o))
    else $error("header and payload flagged on the same item");

  a_end_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_end_o) |-> payload_valid_o)
    else $error("payload end without payload");

  a_verdict_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o) |-> buffer_done_o)
    else $error("verdict raised before the end of the buffer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_out)))
    else $error("stalled result item changed");
`endif

endmodule
